[sv/pdf_pkg.sv]
`default_nettype none

package pdf_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned HEADER_LEN = 4;
    localparam int unsigned HDR_IDX_W  = $clog2(HEADER_LEN);
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic [BYTE_W-1:0] LENGTH_POS = 8'd5;

    typedef logic [BYTE_W-1:0] t_byte;

    localparam logic [CFG_IDX_W-1:0] REG_START_STANDARD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_FLOOD     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_ACK       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ACK_FLOOD = 8'd3;

    localparam t_byte RST_START_STANDARD  = 8'd1;
    localparam t_byte RST_START_FLOOD     = 8'd2;
    localparam t_byte RST_START_ACK       = 8'd3;
    localparam t_byte RST_START_ACK_FLOOD = 8'd4;

    typedef struct packed {
        t_byte byte_value;
        logic  is_packet_byte;
        t_byte byte_position;
        logic  packet_done;
        t_byte packet_type;
        t_byte dest_addr;
        t_byte hop_count;
        t_byte source_addr;
        t_byte packet_length;
        t_byte peer_buffer_depth;
    } t_result;

endpackage

`default_nettype wire

[sv/packet_deframer_unit.sv]
`default_nettype none

// Byte-serial packet deframer. One received byte per beat in, one result beat out per
// byte, registered through a single result register; a new byte can be
// taken every cycle, limited only by the downstream stall. Outside a packet a byte that
// matches any of the four start-code registers opens a packet; any other byte is
// recorded as the peer's buffer depth. The fifth packet byte is the length, and the
// packet closes on the byte where the count reaches both five and that length; that
// beat carries packet_done and the four header bytes (which read zero otherwise).
// Start-code registers are to be written over the config port only while the block is
// idle (not enforced by the block); writes to unknown indexes are dropped; the config port is always ready.
module packet_deframer_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,

    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [pdf_pkg::BYTE_W-1:0]   i_rx_byte,

    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [pdf_pkg::BYTE_W-1:0]   o_byte_value,
    output logic                         o_is_packet_byte,
    output logic [pdf_pkg::BYTE_W-1:0]   o_byte_position,
    output logic                         o_packet_done,
    output logic [pdf_pkg::BYTE_W-1:0]   o_packet_type,
    output logic [pdf_pkg::BYTE_W-1:0]   o_dest_addr,
    output logic [pdf_pkg::BYTE_W-1:0]   o_hop_count,
    output logic [pdf_pkg::BYTE_W-1:0]   o_source_addr,
    output logic [pdf_pkg::BYTE_W-1:0]   o_packet_length,
    output logic [pdf_pkg::BYTE_W-1:0]   o_peer_buffer_depth,

    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [pdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [pdf_pkg::BYTE_W-1:0]   i_cfg_data
);

    pdf_pkg::t_byte r_code_std, r_code_flood, r_code_ack, r_code_ack_flood;

    logic           r_inside,  n_inside;
    pdf_pkg::t_byte r_count,   n_count;
    pdf_pkg::t_byte r_length,  n_length;
    pdf_pkg::t_byte r_depth,   n_depth;
    pdf_pkg::t_byte r_hdr [pdf_pkg::HEADER_LEN];

    logic             r_out_valid;
    pdf_pkg::t_result r_out, n_out;

    logic             accept;
    logic             is_start;
    logic             hdr_wr;
    logic [pdf_pkg::HDR_IDX_W-1:0] hdr_idx;
    logic [pdf_pkg::BYTE_W:0]      cnt_inc;
    logic             done;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid && i_stall;
    assign accept      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_std       <= pdf_pkg::RST_START_STANDARD;
            r_code_flood     <= pdf_pkg::RST_START_FLOOD;
            r_code_ack       <= pdf_pkg::RST_START_ACK;
            r_code_ack_flood <= pdf_pkg::RST_START_ACK_FLOOD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pdf_pkg::REG_START_STANDARD:  r_code_std       <= i_cfg_data;
                pdf_pkg::REG_START_FLOOD:     r_code_flood     <= i_cfg_data;
                pdf_pkg::REG_START_ACK:       r_code_ack       <= i_cfg_data;
                pdf_pkg::REG_START_ACK_FLOOD: r_code_ack_flood <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        is_start = (i_rx_byte == r_code_std)   || (i_rx_byte == r_code_flood) ||
                   (i_rx_byte == r_code_ack)   || (i_rx_byte == r_code_ack_flood);
        cnt_inc  = {1'b0, r_count} + 9'd1;
        n_inside = r_inside;
        n_count  = r_count;
        n_length = r_length;
        n_depth  = r_depth;
        hdr_wr   = 1'b0;
        hdr_idx  = '0;
        done     = 1'b0;

        if (!r_inside) begin
            if (is_start) begin
                n_inside = 1'b1;
                n_count  = 8'd1;
                hdr_wr   = 1'b1;
            end else begin
                n_depth = i_rx_byte;
            end
        end else begin
            if (r_count < pdf_pkg::BYTE_W'(pdf_pkg::HEADER_LEN)) begin
                hdr_wr  = 1'b1;
                hdr_idx = r_count[pdf_pkg::HDR_IDX_W-1:0];
            end
            if (cnt_inc == {1'b0, pdf_pkg::LENGTH_POS})
                n_length = i_rx_byte;
            if (cnt_inc >= {1'b0, pdf_pkg::LENGTH_POS} && cnt_inc >= {1'b0, n_length}) begin
                done     = 1'b1;
                n_inside = 1'b0;
                n_count  = '0;
            end else begin
                n_count = (cnt_inc[pdf_pkg::BYTE_W]) ? '1 : cnt_inc[pdf_pkg::BYTE_W-1:0];
            end
        end

        n_out.byte_value        = i_rx_byte;
        n_out.is_packet_byte    = r_inside || is_start;
        n_out.byte_position     = r_inside ? r_count : '0;
        n_out.packet_done       = done;
        // byte 3 can only be written on a closing beat if the packet closed before its fifth byte,
        // which cannot happen; header registers are read as they stand
        n_out.packet_type       = done ? r_hdr[0] : '0;
        n_out.dest_addr         = done ? r_hdr[1] : '0;
        n_out.hop_count         = done ? r_hdr[2] : '0;
        n_out.source_addr       = done ? r_hdr[3] : '0;
        n_out.packet_length     = n_length;
        n_out.peer_buffer_depth = n_depth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_count     <= '0;
            r_length    <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < pdf_pkg::HEADER_LEN; k++) begin
                r_hdr[k] <= '0;
            end
        end else begin
            if (accept) begin
                r_inside <= n_inside;
                r_count  <= n_count;
                r_length <= n_length;
                r_depth  <= n_depth;
                if (hdr_wr)
                    r_hdr[hdr_idx] <= i_rx_byte;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept)
            r_out <= n_out;
    end

    assign o_valid             = r_out_valid;
    assign o_byte_value        = r_out.byte_value;
    assign o_is_packet_byte    = r_out.is_packet_byte;
    assign o_byte_position     = r_out.byte_position;
    assign o_packet_done       = r_out.packet_done;
    assign o_packet_type       = r_out.packet_type;
    assign o_dest_addr         = r_out.dest_addr;
    assign o_hop_count         = r_out.hop_count;
    assign o_source_addr       = r_out.source_addr;
    assign o_packet_length     = r_out.packet_length;
    assign o_peer_buffer_depth = r_out.peer_buffer_depth;

`ifndef SYNTH
    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inside |-> r_count == '0)
        else $error("byte count not cleared outside a packet");

    a_done_is_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_packet_done |-> o_is_packet_byte && o_byte_position >= 8'd4)
        else $error("packet closed before the length byte");

    a_depth_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_packet_byte |-> o_byte_position == '0 && !o_packet_done
                                         && o_peer_buffer_depth == o_byte_value)
        else $error("buffer-depth beat malformed");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && done |=> !r_inside && r_count == '0)
        else $error("packet state not reset after close");
`endif

endmodule

`default_nettype wire

[bench/packet_deframer_unit_tb.sv]
`default_nettype none

module packet_deframer_unit_tb;

    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam logic [pdf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd4;
    localparam logic [pdf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    pdf_pkg::t_byte                i_rx_byte = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    pdf_pkg::t_byte                o_byte_value;
    logic                          o_is_packet_byte;
    pdf_pkg::t_byte                o_byte_position;
    logic                          o_packet_done;
    pdf_pkg::t_byte                o_packet_type;
    pdf_pkg::t_byte                o_dest_addr;
    pdf_pkg::t_byte                o_hop_count;
    pdf_pkg::t_byte                o_source_addr;
    pdf_pkg::t_byte                o_packet_length;
    pdf_pkg::t_byte                o_peer_buffer_depth;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [pdf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    pdf_pkg::t_byte                i_cfg_data = '0;

    packet_deframer_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_rx_byte           (i_rx_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_byte_value        (o_byte_value),
        .o_is_packet_byte    (o_is_packet_byte),
        .o_byte_position     (o_byte_position),
        .o_packet_done       (o_packet_done),
        .o_packet_type       (o_packet_type),
        .o_dest_addr         (o_dest_addr),
        .o_hop_count         (o_hop_count),
        .o_source_addr       (o_source_addr),
        .o_packet_length     (o_packet_length),
        .o_peer_buffer_depth (o_peer_buffer_depth),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // deframer state mirror
    pdf_pkg::t_byte   start_code [pdf_pkg::HEADER_LEN];
    logic             in_packet;
    pdf_pkg::t_byte   byte_count;
    pdf_pkg::t_byte   length_held;
    pdf_pkg::t_byte   header [pdf_pkg::HEADER_LEN];
    pdf_pkg::t_byte   depth_held;

    pdf_pkg::t_byte   byte_queue [$];
    pdf_pkg::t_result expected_results [$];
    int unsigned pushed_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned errors = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    int unsigned hold_req = 0;
    int unsigned hold_done = 0;
    int unsigned quiet_cycles = 0;
    bit          send_gaps_on = 1'b0;
    bit          recv_gaps_on = 1'b0;

    pdf_pkg::t_byte directed_bytes [26] = '{
        8'h00, 8'hFF,
        8'h01, 8'hAA, 8'h55, 8'h3C, 8'h00,
        8'h02, 8'hFF, 8'h00, 8'h80, 8'h08, 8'h01, 8'h03, 8'h04,
        8'h03, 8'h12, 8'h34, 8'h56, 8'h05,
        8'h04, 8'h7F, 8'h80, 8'h01, 8'h06, 8'hFE
    };

    function automatic bit is_start_code(pdf_pkg::t_byte b);
        return b == start_code[0] || b == start_code[1] ||
               b == start_code[2] || b == start_code[3];
    endfunction

    function automatic pdf_pkg::t_result deframe_byte(pdf_pkg::t_byte b);
        pdf_pkg::t_result r;
        int unsigned      cnt;
        r = '0;
        r.byte_value = b;
        if (!in_packet) begin
            if (is_start_code(b)) begin
                in_packet = 1'b1;
                header[0] = b;
                byte_count = 8'd1;
                r.is_packet_byte = 1'b1;
            end else begin
                depth_held = b;
            end
        end else begin
            cnt = byte_count;
            r.is_packet_byte = 1'b1;
            r.byte_position = byte_count;
            if (cnt < pdf_pkg::HEADER_LEN) header[cnt] = b;
            cnt++;
            if (cnt == pdf_pkg::LENGTH_POS) length_held = b;
            if (cnt >= pdf_pkg::LENGTH_POS && cnt >= length_held) begin
                r.packet_done = 1'b1;
                r.packet_type = header[0];
                r.dest_addr = header[1];
                r.hop_count = header[2];
                r.source_addr = header[3];
                in_packet = 1'b0;
                cnt = 0;
            end
            byte_count = pdf_pkg::t_byte'(cnt);
        end
        r.packet_length = length_held;
        r.peer_buffer_depth = depth_held;
        return r;
    endfunction

    task automatic push_byte(input pdf_pkg::t_byte b);
        byte_queue.push_back(b);
        pushed_cnt++;
    endtask

    task automatic queue_packet(input pdf_pkg::t_byte len);
        int unsigned total;
        total = (len < pdf_pkg::LENGTH_POS) ? pdf_pkg::LENGTH_POS : len;
        push_byte(start_code[$urandom_range(0, pdf_pkg::HEADER_LEN - 1)]);
        repeat (3) push_byte(pdf_pkg::t_byte'($urandom_range(0, 255)));
        push_byte(len);
        repeat (total - pdf_pkg::LENGTH_POS) push_byte(pdf_pkg::t_byte'($urandom_range(0, 255)));
    endtask

    task automatic fill_random(input int unsigned n_bytes);
        int unsigned    target;
        pdf_pkg::t_byte b;
        target = pushed_cnt + n_bytes;
        while (pushed_cnt < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    case ($urandom_range(0, 9))
                        0: b = pdf_pkg::t_byte'($urandom_range(0, 4));
                        1: b = pdf_pkg::t_byte'($urandom_range(25, 80));
                        default: b = pdf_pkg::t_byte'($urandom_range(5, 24));
                    endcase
                    queue_packet(b);
                end
                6, 7: begin
                    do b = pdf_pkg::t_byte'($urandom_range(0, 255)); while (is_start_code(b));
                    push_byte(b);
                end
                default: push_byte(pdf_pkg::t_byte'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic write_reg(input logic [pdf_pkg::CFG_IDX_W-1:0] idx,
                             input pdf_pkg::t_byte val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            pdf_pkg::REG_START_STANDARD:  start_code[0] = val;
            pdf_pkg::REG_START_FLOOD:     start_code[1] = val;
            pdf_pkg::REG_START_ACK:       start_code[2] = val;
            pdf_pkg::REG_START_ACK_FLOOD: start_code[3] = val;
            default: ;
        endcase
    endtask

    task automatic set_codes(input pdf_pkg::t_byte s, input pdf_pkg::t_byte f,
                             input pdf_pkg::t_byte a, input pdf_pkg::t_byte af);
        write_reg(pdf_pkg::REG_START_STANDARD, s);
        write_reg(pdf_pkg::REG_START_FLOOD, f);
        write_reg(pdf_pkg::REG_START_ACK, a);
        write_reg(pdf_pkg::REG_START_ACK_FLOOD, af);
    endtask

    task automatic drain(input bit hold);
        if (hold) hold_req++;
        while (accepted_cnt != pushed_cnt || expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input pdf_pkg::t_byte want,
                               input pdf_pkg::t_byte got);
        if (want !== got) begin
            $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(deframe_byte(i_rx_byte));
                accepted_cnt++;
            end
            if (!(i_valid && o_stall)) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    i_rx_byte <= byte_queue.pop_front();
                    i_valid <= 1'b1;
                    send_wait = send_gaps_on ? $urandom_range(0, 10) : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        pdf_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected beat: expected none, got byte_value %0h",
                             $time, o_byte_value);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("byte_value", want.byte_value, o_byte_value);
                    check_field("is_packet_byte", pdf_pkg::t_byte'(want.is_packet_byte),
                                pdf_pkg::t_byte'(o_is_packet_byte));
                    check_field("byte_position", want.byte_position, o_byte_position);
                    check_field("packet_done", pdf_pkg::t_byte'(want.packet_done),
                                pdf_pkg::t_byte'(o_packet_done));
                    check_field("packet_type", want.packet_type, o_packet_type);
                    check_field("dest_addr", want.dest_addr, o_dest_addr);
                    check_field("hop_count", want.hop_count, o_hop_count);
                    check_field("source_addr", want.source_addr, o_source_addr);
                    check_field("packet_length", want.packet_length, o_packet_length);
                    check_field("peer_buffer_depth", want.peer_buffer_depth,
                                o_peer_buffer_depth);
                end
                recv_wait = recv_gaps_on ? $urandom_range(0, 10) : 0;
            end
            if (hold_done != hold_req) begin
                hold_done = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[packet_deframer_unit] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        start_code[0] = pdf_pkg::RST_START_STANDARD;
        start_code[1] = pdf_pkg::RST_START_FLOOD;
        start_code[2] = pdf_pkg::RST_START_ACK;
        start_code[3] = pdf_pkg::RST_START_ACK_FLOOD;
        in_packet = 1'b0;
        byte_count = '0;
        length_held = '0;
        depth_held = '0;
        foreach (header[k]) header[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset codes: depth bytes, short length, codes as data, exact length
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        foreach (directed_bytes[k]) push_byte(directed_bytes[k]);
        drain(1'b0);

        // extreme codes; unmapped indexes must be dropped
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b0;
        set_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
        write_reg(REG_UNMAPPED_LO, 8'h55);
        write_reg(REG_UNMAPPED_HI, 8'hAA);
        push_byte(8'h55);
        push_byte(8'hAA);
        fill_random(30);
        drain(1'b0);

        // all codes equal, long receiver hold-off
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b1;
        begin : equal_codes
            pdf_pkg::t_byte c;
            c = pdf_pkg::t_byte'($urandom_range(0, 255));
            set_codes(c, c, c, c);
        end
        fill_random(30);
        drain(1'b1);

        // random codes, one maximum-length packet
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b0;
        set_codes(pdf_pkg::t_byte'($urandom_range(0, 255)),
                  pdf_pkg::t_byte'($urandom_range(0, 255)),
                  pdf_pkg::t_byte'($urandom_range(0, 255)),
                  pdf_pkg::t_byte'($urandom_range(0, 255)));
        queue_packet(8'd255);
        fill_random(30);
        drain(1'b0);

        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b1;
        set_codes(8'hFF, 8'hFF, 8'h00, 8'h00);
        fill_random(30);
        drain(1'b1);

        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        set_codes(pdf_pkg::RST_START_STANDARD, pdf_pkg::RST_START_FLOOD,
                  pdf_pkg::RST_START_ACK, pdf_pkg::RST_START_ACK_FLOOD);
        fill_random(30);
        drain(1'b0);

        if (errors == 0) begin
            $display("[packet_deframer_unit] OK");
        end else begin
            $display("[packet_deframer_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
sv/pdf_pkg.sv
sv/packet_deframer_unit.sv
bench/packet_deframer_unit_tb.sv
